@@ sv/slpl_pkg.sv @@
`timescale 1ns / 1ps

package slpl_pkg;

    localparam int DELAY_DEPTH = 512;
    localparam int AW          = $clog2(DELAY_DEPTH);
    localparam int SMP_W       = 24;
    localparam int GAIN_W      = 24;
    localparam int FRAC_W      = 23;
    localparam int DLY_W       = 9;
    localparam int PROD_W      = SMP_W + GAIN_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(1 << FRAC_W);

    localparam logic [GAIN_W-1:0] RST_CEILING = UNITY;
    localparam logic [GAIN_W-1:0] RST_ATTACK  = GAIN_W'(343669);
    localparam logic [GAIN_W-1:0] RST_RELEASE = GAIN_W'(1744);
    localparam logic [GAIN_W-1:0] RST_FLOOR   = '0;
    localparam logic [DLY_W-1:0]  RST_DELAY   = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CEILING = 3'd0,
        CFG_ATTACK  = 3'd1,
        CFG_RELEASE = 3'd2,
        CFG_FLOOR   = 3'd3,
        CFG_DELAY   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] ceiling;
        logic [GAIN_W-1:0] attack_coeff;
        logic [GAIN_W-1:0] release_coeff;
        logic [GAIN_W-1:0] gain_floor;
        logic [DLY_W-1:0]  lookahead_delay;
    } t_cfg;

    typedef struct packed {
        logic signed [SMP_W-1:0] left_sample;
        logic signed [SMP_W-1:0] right_sample;
    } t_in;

    typedef struct packed {
        logic signed [SMP_W-1:0] left_out;
        logic signed [SMP_W-1:0] right_out;
        logic [GAIN_W-1:0]       applied_gain;
    } t_out;

endpackage

@@ sv/slpl_ring.sv @@
`timescale 1ns / 1ps

module slpl_ring (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [slpl_pkg::AW-1:0] i_waddr,
    input  slpl_pkg::t_in         i_wdata,
    input  logic                  i_re,
    input  logic [slpl_pkg::AW-1:0] i_raddr,
    output slpl_pkg::t_in         o_rdata
);
    import slpl_pkg::*;

    t_in r_mem [DELAY_DEPTH];
    t_in r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/slpl_div.sv @@
`timescale 1ns / 1ps

module slpl_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [slpl_pkg::GAIN_W-1:0] i_dividend,
    input  logic [slpl_pkg::SMP_W-1:0]  i_divisor,
    output logic                      o_done,
    output logic [slpl_pkg::GAIN_W-1:0] o_quotient
);
    import slpl_pkg::*;

    localparam int CNT_W = $clog2(FRAC_W + 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [SMP_W-1:0]  r_rem;
    logic [SMP_W-1:0]  r_dvs;
    logic [FRAC_W-1:0] r_quo;
    logic [SMP_W:0]    n_trial;
    logic              n_fit;

    assign n_trial = {r_rem, 1'b0};
    assign n_fit   = (n_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(FRAC_W);
            r_rem  <= i_dividend;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
                r_rem <= n_fit ? SMP_W'(n_trial - {1'b0, r_dvs}) : SMP_W'(n_trial);
                r_quo <= {r_quo[FRAC_W-2:0], n_fit};
            end
        end
    end

    assign o_done     = r_busy && (r_cnt == '0);
    assign o_quotient = GAIN_W'(r_quo);

endmodule

@@ sv/slpl_core.sv @@
`timescale 1ns / 1ps

module slpl_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  slpl_pkg::t_cfg i_cfg,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  slpl_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output slpl_pkg::t_out o_out_data
);
    import slpl_pkg::*;

    localparam int STEP_W = PROD_W - FRAC_W + 1;
    localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(1) << (FRAC_W - 1);
    localparam logic [SMP_W-1:0] MAX_POS = {1'b0, {(SMP_W - 1){1'b1}}};

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_PEAK, S_CMP, S_DIV, S_DIFF,
        S_SMUL, S_STEP, S_FLOOR, S_LMUL, S_RMUL, S_FIN
    } t_state;

    function automatic logic signed [SMP_W-1:0] f_scale(input logic [PROD_W-1:0] prod,
                                                         input logic neg);
        logic [PROD_W:0]  rnd;
        logic [SMP_W-1:0] m;
        rnd = {1'b0, prod} + HALF;
        m   = rnd[FRAC_W+SMP_W-1:FRAC_W];
        if (neg) begin
            return $signed(SMP_W'(0) - m);
        end else if (m > MAX_POS) begin
            return $signed(MAX_POS);
        end
        return $signed(m);
    endfunction

    function automatic logic [SMP_W-1:0] f_mag(input logic signed [SMP_W-1:0] s);
        return s[SMP_W-1] ? SMP_W'(0) - SMP_W'(s) : SMP_W'(s);
    endfunction

    function automatic logic [GAIN_W-1:0] f_cap(input logic [GAIN_W-1:0] v);
        return (v > UNITY) ? UNITY : v;
    endfunction

    t_state                  r_state;
    logic [AW-1:0]           r_wp;
    logic                    r_full;
    logic                    r_rd_ok;
    logic [GAIN_W-1:0]       r_gain;
    logic signed [SMP_W-1:0] r_dl;
    logic signed [SMP_W-1:0] r_dr;
    logic [SMP_W-1:0]        r_ml;
    logic [SMP_W-1:0]        r_mr;
    logic [GAIN_W-1:0]       r_target;
    logic [GAIN_W-1:0]       r_diff;
    logic [GAIN_W-1:0]       r_coeff;
    logic                    r_fall;
    logic [PROD_W-1:0]       r_prod;
    logic [GAIN_W-1:0]       r_app;
    logic signed [SMP_W-1:0] r_lo;
    t_out                    r_out;
    logic                    r_out_valid;

    logic [AW-1:0]     n_dly;
    logic [AW-1:0]     n_rp;
    logic [AW-1:0]     n_wp;
    logic              n_we;
    t_in               n_rdata;
    t_in               n_rd;
    logic [SMP_W-1:0]  n_peak;
    logic              n_div_start;
    logic              n_div_done;
    logic [GAIN_W-1:0] n_quo;
    logic              n_fall;
    logic [SMP_W-1:0]  n_mul_a;
    logic [GAIN_W-1:0] n_mul_b;
    logic [PROD_W-1:0] n_prod;
    logic [PROD_W:0]   n_rnd;
    logic [STEP_W-1:0] n_step;
    logic [GAIN_W-1:0] n_floor;
    logic              n_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign n_we       = o_in_ready && i_in_valid;

    assign n_dly = (32'(i_cfg.lookahead_delay) >= DELAY_DEPTH) ?
                   AW'(DELAY_DEPTH - 1) : AW'(i_cfg.lookahead_delay);
    assign n_rp  = (n_dly <= r_wp) ? r_wp - n_dly :
                   AW'(32'(r_wp) + DELAY_DEPTH - 32'(n_dly));
    assign n_wp  = (32'(r_wp) == DELAY_DEPTH - 1) ? '0 : r_wp + 1'b1;

    slpl_ring u_ring (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (r_wp),
        .i_wdata (i_in_data),
        .i_re    (r_state == S_READ),
        .i_raddr (n_rp),
        .o_rdata (n_rdata)
    );

    assign n_rd        = r_rd_ok ? n_rdata : '0;
    assign n_peak      = (r_ml > r_mr) ? r_ml : r_mr;
    assign n_div_start = (r_state == S_CMP) && (n_peak > i_cfg.ceiling);

    slpl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend (i_cfg.ceiling),
        .i_divisor  (n_peak),
        .o_done     (n_div_done),
        .o_quotient (n_quo)
    );

    assign n_fall = r_target < r_gain;

    always_comb begin
        case (r_state)
            S_LMUL:  begin n_mul_a = r_ml;   n_mul_b = r_app;   end
            S_RMUL:  begin n_mul_a = r_mr;   n_mul_b = r_app;   end
            default: begin n_mul_a = r_diff; n_mul_b = r_coeff; end
        endcase
    end
    assign n_prod = PROD_W'(n_mul_a) * PROD_W'(n_mul_b);

    always_comb begin
        n_rnd  = {1'b0, r_prod} + HALF;
        n_step = n_rnd[PROD_W:FRAC_W];
        if (n_step == '0 && r_diff != '0 && r_coeff != '0) begin
            n_step = STEP_W'(1);
        end
        if (n_step > STEP_W'(r_diff)) begin
            n_step = STEP_W'(r_diff);
        end
    end

    assign n_floor = f_cap(i_cfg.gain_floor);
    assign n_load  = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_full      <= 1'b0;
            r_gain      <= UNITY;
            r_out_valid <= 1'b0;
        end else begin
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_we) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_rd_ok <= r_full || (n_dly <= r_wp);
                    r_wp    <= n_wp;
                    if (32'(r_wp) == DELAY_DEPTH - 1) begin
                        r_full <= 1'b1;
                    end
                    r_state <= S_PEAK;
                end
                S_PEAK: begin
                    r_dl    <= n_rd.left_sample;
                    r_dr    <= n_rd.right_sample;
                    r_ml    <= f_mag(n_rd.left_sample);
                    r_mr    <= f_mag(n_rd.right_sample);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (n_div_start) begin
                        r_state <= S_DIV;
                    end else begin
                        r_target <= UNITY;
                        r_state  <= S_DIFF;
                    end
                end
                S_DIV: begin
                    if (n_div_done) begin
                        r_target <= n_quo;
                        r_state  <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_fall  <= n_fall;
                    r_diff  <= n_fall ? r_gain - r_target : r_target - r_gain;
                    r_coeff <= f_cap(n_fall ? i_cfg.attack_coeff : i_cfg.release_coeff);
                    r_state <= S_SMUL;
                end
                S_SMUL: begin
                    r_prod  <= n_prod;
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    r_gain  <= r_fall ? r_gain - GAIN_W'(n_step) : r_gain + GAIN_W'(n_step);
                    r_state <= S_FLOOR;
                end
                S_FLOOR: begin
                    r_app   <= (r_gain < n_floor) ? n_floor : r_gain;
                    r_state <= S_LMUL;
                end
                S_LMUL: begin
                    r_prod  <= n_prod;
                    r_state <= S_RMUL;
                end
                S_RMUL: begin
                    r_lo    <= f_scale(r_prod, r_dl[SMP_W-1]);
                    r_prod  <= n_prod;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (n_load) begin
                        r_out.left_out     <= r_lo;
                        r_out.right_out    <= f_scale(r_prod, r_dr[SMP_W-1]);
                        r_out.applied_gain <= r_app;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ sv/stereo_lookahead_peak_limiter_top.sv @@
`timescale 1ns / 1ps

// Stereo lookahead peak limiter, Q1.23 gain (0x800000 is unity).
// Input channel: one beat carries a left and right 24-bit sample pair.
// Output channel: one beat per input beat, the delayed pair scaled by the
// applied gain and saturated, plus that gain.
// An item passes through read, peak, compare, divide (only when the delayed
// peak exceeds the ceiling: the 23-step restoring divider forms ceiling /
// peak), difference, smoothing step, floor and the two sample multiplies.
// Both samples share one 24x24 multiplier with the smoothing step. One item
// is in flight at a time: a new input beat is taken only once it is done.
// The delay rings sit in one 512-entry memory; a wrap flag beside the write
// position makes entries not yet written since reset read as zero, so no
// clearing pass is needed.
// Reset (synchronous, active low) restores the registers, unity gain and an
// empty ring. A finished result waits in the output register while the next
// item is taken; if the receiver still stalls when that item is done, the
// block holds it and takes no further input. Configuration writes are
// registered; the user must make them while the block is idle (unchecked).
module stereo_lookahead_peak_limiter_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  slpl_pkg::t_in                    i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output slpl_pkg::t_out                   o_out_data,
    input  logic                             i_cfg_we,
    input  logic [slpl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [slpl_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import slpl_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ceiling         <= RST_CEILING;
            r_cfg.attack_coeff    <= RST_ATTACK;
            r_cfg.release_coeff   <= RST_RELEASE;
            r_cfg.gain_floor      <= RST_FLOOR;
            r_cfg.lookahead_delay <= RST_DELAY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CEILING: r_cfg.ceiling         <= GAIN_W'(i_cfg_wdata);
                CFG_ATTACK:  r_cfg.attack_coeff    <= GAIN_W'(i_cfg_wdata);
                CFG_RELEASE: r_cfg.release_coeff   <= GAIN_W'(i_cfg_wdata);
                CFG_FLOOR:   r_cfg.gain_floor      <= GAIN_W'(i_cfg_wdata);
                CFG_DELAY:   r_cfg.lookahead_delay <= i_cfg_wdata[DLY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    slpl_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
